@@ src/bgb_pkg.sv @@
// ----------------------------------------------------------------------------
// bgb_pkg
// Shared types, constants and helper functions of the bitmap glyph blitter.
// ----------------------------------------------------------------------------
`default_nettype none

package bgb_pkg;

   // block constants
   localparam int BYTES_PER_PIXEL  = 4;
   localparam int MAX_GLYPH_WIDTH  = 16;
   localparam int MAX_GLYPH_HEIGHT = 32;
   localparam int NUM_GLYPHS       = 256;
   localparam int FONT_STORE_BYTES = 16384;

   // field widths
   localparam int FONT_AW   = $clog2(FONT_STORE_BYTES);
   localparam int BYTE_W    = 8;
   localparam int CODE_W    = $clog2(NUM_GLYPHS);
   localparam int POS_W     = 12;
   localparam int COLOR_W   = 32;
   localparam int ADDR_W    = 48;
   localparam int PITCH_W   = 16;
   localparam int GW_W      = 5;
   localparam int GH_W      = 6;
   localparam int GB_W      = 7;
   localparam int MASK_W    = 16;
   localparam int ROW_W     = $clog2(MAX_GLYPH_HEIGHT);
   localparam int YPITCH_W  = POS_W + PITCH_W;
   localparam int PROD_W    = CODE_W + GB_W;
   localparam int BPP_SH    = $clog2(BYTES_PER_PIXEL);
   localparam int CSR_IDX_W = 3;
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 96;

   // command queue between front and back end
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_BASE   = 3'd0,
      CSR_PITCH_BYTES  = 3'd1,
      CSR_GLYPH_WIDTH  = 3'd2,
      CSR_GLYPH_HEIGHT = 3'd3,
      CSR_GLYPH_BYTES  = 3'd4
   } csr_idx_type;

   // item kinds
   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_DRAW = 1'b1
   } op_type;

   // back end sequencer states
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_RD_HI,
      BK_ROW
   } bk_state_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  frame_base;
      logic [PITCH_W-1:0] pitch_bytes;
      logic [GW_W-1:0]    glyph_width;
      logic [GH_W-1:0]    glyph_height;
      logic [GB_W-1:0]    glyph_bytes;
   } cfg_type;

   // classified command; addr is the load address or the glyph start
   typedef struct packed {
      op_type              op;
      logic [FONT_AW-1:0]  addr;
      logic [BYTE_W-1:0]   font_byte;
      logic [POS_W-1:0]    x_pos;
      logic [YPITCH_W-1:0] y_offset;
      logic [COLOR_W-1:0]  color;
   } cmd_type;

   // font store access from the back end
   typedef struct packed {
      logic               wr_en;
      logic [FONT_AW-1:0] wr_addr;
      logic [BYTE_W-1:0]  wr_data;
      logic               rd_en;
      logic [FONT_AW-1:0] rd_addr;
   } ram_req_type;

   // width saturated to the widest glyph
   function automatic logic [GW_W-1:0] sat_width(input logic [GW_W-1:0] gw);
      logic [GW_W-1:0] lim;
      lim = GW_W'(MAX_GLYPH_WIDTH);
      return (gw > lim) ? lim : gw;
   endfunction

   // height saturated to the tallest glyph
   function automatic logic [GH_W-1:0] sat_height(input logic [GH_W-1:0] gh);
      logic [GH_W-1:0] lim;
      lim = GH_W'(MAX_GLYPH_HEIGHT);
      return (gh > lim) ? lim : gh;
   endfunction

   // ones in the low w columns
   function automatic logic [MASK_W-1:0] width_mask(input logic [GW_W-1:0] w);
      logic [MASK_W:0] t;
      t = ((MASK_W+1)'(1) << w) - (MASK_W+1)'(1);
      return t[MASK_W-1:0];
   endfunction

   // font bytes hold the leftmost pixel in the msb
   function automatic logic [BYTE_W-1:0] rev8(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] r;
      for (int i = 0; i < BYTE_W; i++) begin
         r[i] = b[BYTE_W-1-i];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ src/bitmap_glyph_blitter.sv @@
// ----------------------------------------------------------------------------
// bitmap_glyph_blitter
// Bitmap font glyph renderer: font store loading and per-row mask output.
// ----------------------------------------------------------------------------
// A load transaction (req_tuser low) writes one byte of the 16 KiB font
// store; a draw transaction (req_tuser high) produces one response per glyph
// row carrying the framebuffer address of the row's leftmost pixel, a column
// mask (bit i = column i) and the color, with rsp_tlast on the final row.
// Requests pass a holding stage and a four-entry command queue, so the
// request side keeps flowing while the row sequencer works. The sequencer
// reads one font byte per glyph row for glyphs up to 8 pixels wide and two
// bytes per row for 9 to 16 pixels, through the single read port of the font
// store, and holds a row while the response output is stalled. Configuration
// writes are always ready and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_glyph_blitter
   import bgb_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // configuration write channel
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [ADDR_W-1:0]     csr_data,
   // request stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // font_addr[13:0], font_byte[21:14], char_code[29:22], x_pos[41:30],
   // y_pos[53:42], color[85:54], zero[87:86]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // op[0]
   input  wire logic                  req_tuser,
   // response stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // row_addr[47:0], pixel_mask[63:48], row_color[95:64]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast
);

   cfg_type           cfg_ff, cfg_in;
   logic              q_push, q_pop, q_empty, q_full;
   cmd_type           q_wdata, q_rdata;
   ram_req_type       ram_req;
   logic [BYTE_W-1:0] ram_rdata;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FRAME_BASE:   cfg_in.frame_base   = csr_data;
            CSR_PITCH_BYTES:  cfg_in.pitch_bytes  = csr_data[PITCH_W-1:0];
            CSR_GLYPH_WIDTH:  cfg_in.glyph_width  = csr_data[GW_W-1:0];
            CSR_GLYPH_HEIGHT: cfg_in.glyph_height = csr_data[GH_W-1:0];
            CSR_GLYPH_BYTES:  cfg_in.glyph_bytes  = csr_data[GB_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_base   <= '0;
         cfg_ff.pitch_bytes  <= PITCH_W'(4096);
         cfg_ff.glyph_width  <= GW_W'(8);
         cfg_ff.glyph_height <= GH_W'(16);
         cfg_ff.glyph_bytes  <= GB_W'(16);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end: accept and classify
   bgb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_push     (q_push),
      .q_wdata    (q_wdata),
      .q_full     (q_full)
   );

   // command queue
   bgb_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty),
      .full  (q_full)
   );

   // font store
   bgb_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (FONT_STORE_BYTES)
   ) u_font_store (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.rd_addr),
      .rd_data (ram_rdata)
   );

   // back end: row sequencer
   bgb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .q_rdata    (q_rdata),
      .ram_req    (ram_req),
      .ram_rdata  (ram_rdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // queue never written when full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("command queue overflow");

   // queue never read when empty
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("command queue underflow");

   // font store never written and read in the same cycle
   a_port_excl: assert property (@(posedge clock) disable iff (reset)
      ram_req.wr_en |-> !ram_req.rd_en)
      else $error("font store write and read collide");

   // no mask bit beyond the glyph width
   a_mask_width: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[63:48] & ~width_mask(sat_width(cfg_ff.glyph_width)))
                      == '0))
      else $error("pixel mask wider than glyph");

endmodule

`default_nettype wire

@@ src/bgb_ram.sv @@
// ----------------------------------------------------------------------------
// bgb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bgb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read, holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ src/bgb_front.sv @@
// ----------------------------------------------------------------------------
// bgb_front
// Accepts request transactions, classifies them and precomputes the glyph
// start address and the vertical byte offset before queuing.
// ----------------------------------------------------------------------------
`default_nettype none

module bgb_front
   import bgb_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cfg_type               cfg,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tuser,
   output logic                       q_push,
   output cmd_type                    q_wdata,
   input  wire logic                  q_full
);

   typedef struct packed {
      op_type             op;
      logic [FONT_AW-1:0] font_addr;
      logic [BYTE_W-1:0]  font_byte;
      logic [CODE_W-1:0]  char_code;
      logic [POS_W-1:0]   x_pos;
      logic [POS_W-1:0]   y_pos;
      logic [COLOR_W-1:0] color;
   } hold_type;

   logic     hold_valid_ff, hold_valid_in;
   hold_type hold_ff, hold_in;
   logic     req_accept;
   logic [PROD_W-1:0]   glyph_prod;
   logic [YPITCH_W-1:0] y_offset;

   // input holding stage
   assign req_tready = !hold_valid_ff || !q_full;
   assign req_accept = req_tvalid && req_tready;
   assign q_push     = hold_valid_ff && !q_full;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (req_accept) begin
         hold_valid_in = 1'b1;
      end else if (q_push) begin
         hold_valid_in = 1'b0;
      end
   end

   // unpack the transaction
   always_comb begin
      hold_in           = hold_ff;
      if (req_accept) begin
         hold_in.op        = op_type'(req_tuser);
         hold_in.font_addr = req_tdata[13:0];
         hold_in.font_byte = req_tdata[21:14];
         hold_in.char_code = req_tdata[29:22];
         hold_in.x_pos     = req_tdata[41:30];
         hold_in.y_pos     = req_tdata[53:42];
         hold_in.color     = req_tdata[85:54];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

   // glyph start and row offset products
   assign glyph_prod = PROD_W'(hold_ff.char_code) * PROD_W'(cfg.glyph_bytes);
   assign y_offset   = YPITCH_W'(hold_ff.y_pos) * YPITCH_W'(cfg.pitch_bytes);

   // classified command
   always_comb begin
      q_wdata.op        = hold_ff.op;
      q_wdata.font_byte = hold_ff.font_byte;
      q_wdata.x_pos     = hold_ff.x_pos;
      q_wdata.y_offset  = y_offset;
      q_wdata.color     = hold_ff.color;
      if (hold_ff.op == OP_LOAD) begin
         q_wdata.addr = hold_ff.font_addr;
      end else begin
         q_wdata.addr = glyph_prod[FONT_AW-1:0];
      end
   end

endmodule

`default_nettype wire

@@ src/bgb_fifo.sv @@
// ----------------------------------------------------------------------------
// bgb_fifo
// Short command queue between the front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bgb_fifo
   import bgb_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type wdata,
   input  wire logic    pop,
   output cmd_type      rdata,
   output logic         empty,
   output logic         full
);

   cmd_type           entry_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == (QPTR_W+1)'(QDEPTH));
   assign rdata = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

@@ src/bgb_back.sv @@
// ----------------------------------------------------------------------------
// bgb_back
// Executes queued commands: writes font bytes, and walks the glyph rows of a
// draw, reading the font store and emitting one response per row.
// ----------------------------------------------------------------------------
`default_nettype none

module bgb_back
   import bgb_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cfg_type               cfg,
   input  wire logic                  q_empty,
   output logic                       q_pop,
   input  wire cmd_type               q_rdata,
   output ram_req_type                ram_req,
   input  wire logic [BYTE_W-1:0]     ram_rdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast
);

   bk_state_type       state_ff, state_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [FONT_AW-1:0] byte_addr_ff, byte_addr_in;
   logic [ADDR_W-1:0]  row_addr_ff, row_addr_in;
   logic [COLOR_W-1:0] color_ff, color_in;
   logic [BYTE_W-1:0]  lo_ff, lo_in;

   logic               out_valid_ff, out_valid_in;
   logic [ADDR_W-1:0]  out_addr_ff, out_addr_in;
   logic [MASK_W-1:0]  out_mask_ff, out_mask_in;
   logic [COLOR_W-1:0] out_color_ff, out_color_in;
   logic               out_last_ff, out_last_in;

   logic [GW_W-1:0]    width;
   logic [GH_W-1:0]    height;
   logic               two_byte;
   logic [FONT_AW-1:0] byte_step;
   logic               last_row;
   logic               out_free;
   logic               start_draw;
   logic               emit;
   logic [BYTE_W-1:0]  lo_byte, hi_byte;
   logic [MASK_W-1:0]  row_mask;
   logic [ADDR_W-1:0]  first_addr;

   // glyph geometry from the configuration
   assign width      = sat_width(cfg.glyph_width);
   assign height     = sat_height(cfg.glyph_height);
   assign two_byte   = (width > GW_W'(BYTE_W));
   assign byte_step  = two_byte ? FONT_AW'(2) : FONT_AW'(1);
   assign last_row   = (row_ff == ROW_W'(height - 1'b1));
   assign out_free   = !out_valid_ff || rsp_tready;
   assign start_draw = (state_ff == BK_IDLE) && !q_empty && (q_rdata.op == OP_DRAW)
                       && (height != '0);
   assign emit       = (state_ff == BK_ROW) && out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (start_draw) begin
               state_in = two_byte ? BK_RD_HI : BK_ROW;
            end
         end
         BK_RD_HI: begin
            state_in = BK_ROW;
         end
         BK_ROW: begin
            if (out_free) begin
               if (last_row) begin
                  state_in = BK_IDLE;
               end else begin
                  state_in = two_byte ? BK_RD_HI : BK_ROW;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // queue pop and font store access
   always_comb begin
      q_pop           = 1'b0;
      ram_req.wr_en   = 1'b0;
      ram_req.wr_addr = q_rdata.addr;
      ram_req.wr_data = q_rdata.font_byte;
      ram_req.rd_en   = 1'b0;
      ram_req.rd_addr = q_rdata.addr;
      unique case (state_ff)
         BK_IDLE: begin
            q_pop         = !q_empty;
            ram_req.wr_en = !q_empty && (q_rdata.op == OP_LOAD);
            ram_req.rd_en = start_draw;
         end
         BK_RD_HI: begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = byte_addr_ff + 1'b1;
         end
         BK_ROW: begin
            ram_req.rd_en   = out_free && !last_row;
            ram_req.rd_addr = byte_addr_ff + byte_step;
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   // row mask from one or two font bytes
   assign lo_byte    = two_byte ? lo_ff : ram_rdata;
   assign hi_byte    = two_byte ? ram_rdata : '0;
   assign row_mask   = {rev8(hi_byte), rev8(lo_byte)} & width_mask(width);
   assign first_addr = cfg.frame_base + ADDR_W'({q_rdata.x_pos, BPP_SH'(0)})
                       + ADDR_W'(q_rdata.y_offset);

   // row walk registers
   always_comb begin
      row_in       = row_ff;
      byte_addr_in = byte_addr_ff;
      row_addr_in  = row_addr_ff;
      color_in     = color_ff;
      lo_in        = lo_ff;
      if (start_draw) begin
         row_in       = '0;
         byte_addr_in = q_rdata.addr;
         row_addr_in  = first_addr;
         color_in     = q_rdata.color;
      end
      if (state_ff == BK_RD_HI) begin
         lo_in = ram_rdata;
      end
      if (emit) begin
         row_in       = last_row ? '0 : row_ff + 1'b1;
         byte_addr_in = byte_addr_ff + byte_step;
         row_addr_in  = row_addr_ff + ADDR_W'(cfg.pitch_bytes);
      end
   end

   // response output register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_addr_in  = out_addr_ff;
      out_mask_in  = out_mask_ff;
      out_color_in = out_color_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_addr_in  = row_addr_ff;
         out_mask_in  = row_mask;
         out_color_in = color_ff;
         out_last_in  = last_row;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         row_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_addr_ff <= byte_addr_in;
      row_addr_ff  <= row_addr_in;
      color_ff     <= color_in;
      lo_ff        <= lo_in;
      out_addr_ff  <= out_addr_in;
      out_mask_ff  <= out_mask_in;
      out_color_ff <= out_color_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_color_ff, out_mask_ff, out_addr_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bitmap glyph blitter: a shadow font store and
// register copy predict every glyph row response, which a checking process
// compares field by field as response transactions arrive.
// ----------------------------------------------------------------------------

module testbench
   import bgb_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 64;
   localparam int HOLD_CYCLES  = 400;
   // register index that decodes to nothing
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_IDX = 3'd7;

   typedef struct {
      logic [ADDR_W-1:0]  row_addr;
      logic [MASK_W-1:0]  pixel_mask;
      logic [COLOR_W-1:0] row_color;
      logic               last;
   } glyph_row_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [ADDR_W-1:0]      csr_data   = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tlast;

   // shadow state of the block
   logic [BYTE_W-1:0]  font_shadow [FONT_STORE_BYTES];
   bit                 font_loaded [FONT_STORE_BYTES];
   logic [ADDR_W-1:0]  cfg_frame_base = '0;
   logic [PITCH_W-1:0] cfg_pitch      = 16'd4096;
   logic [GW_W-1:0]    cfg_width      = 5'd8;
   logic [GH_W-1:0]    cfg_height     = 6'd16;
   logic [GB_W-1:0]    cfg_gbytes     = 7'd16;

   glyph_row_type pending_rows [$];
   int fail_count    = 0;
   int cycle_count   = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_token    = 0;
   int hold_seen     = 0;
   int hold_left     = 0;

   bitmap_glyph_blitter u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // response side ready, with random idling and a long hold on request
   always @(posedge clock) begin : rsp_sink
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_seen != hold_token) begin
         hold_seen  <= hold_token;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   // compare each response transaction with the oldest predicted row
   always @(posedge clock) begin : row_check
      glyph_row_type got;
      glyph_row_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.row_addr   = rsp_tdata[47:0];
         got.pixel_mask = rsp_tdata[63:48];
         got.row_color  = rsp_tdata[95:64];
         got.last       = rsp_tlast;
         if (pending_rows.size() == 0) begin
            $error("unexpected glyph row: row_addr 0x%0h", got.row_addr);
            fail_count++;
         end else begin
            want = pending_rows.pop_front();
            check_field("row_addr", want.row_addr, got.row_addr);
            check_field("pixel_mask", want.pixel_mask, got.pixel_mask);
            check_field("row_color", want.row_color, got.row_color);
            check_field("last", want.last, got.last);
         end
      end
   end

   // width and height as the block uses them
   function automatic int eff_width();
      return (cfg_width > MAX_GLYPH_WIDTH) ? MAX_GLYPH_WIDTH : int'(cfg_width);
   endfunction

   function automatic int eff_height();
      return (cfg_height > MAX_GLYPH_HEIGHT) ? MAX_GLYPH_HEIGHT : int'(cfg_height);
   endfunction

   // font store byte holding column col of a glyph row
   function automatic logic [FONT_AW-1:0] font_byte_addr(input logic [CODE_W-1:0] code,
                                                         input int row, input int col);
      return FONT_AW'(int'(code) * int'(cfg_gbytes) + row * ((eff_width() + 7) / 8)
                      + col / 8);
   endfunction

   // expected responses of one draw
   function automatic void predict_glyph_rows(input logic [CODE_W-1:0] code,
                                              input logic [POS_W-1:0] x,
                                              input logic [POS_W-1:0] y,
                                              input logic [COLOR_W-1:0] color);
      glyph_row_type row_exp;
      logic [63:0] addr;
      logic [BYTE_W-1:0] bits;
      int w;
      int h;
      w = eff_width();
      h = eff_height();
      for (int row = 0; row < h; row++) begin
         row_exp.pixel_mask = '0;
         for (int col = 0; col < w; col++) begin
            bits = font_shadow[font_byte_addr(code, row, col)];
            if (bits[7 - col % 8]) row_exp.pixel_mask[col] = 1'b1;
         end
         addr = 64'(cfg_frame_base) + 64'(x) * BYTES_PER_PIXEL
              + (64'(y) + 64'(row)) * 64'(cfg_pitch);
         row_exp.row_addr  = addr[ADDR_W-1:0];
         row_exp.row_color = color;
         row_exp.last      = (row == h - 1);
         pending_rows.push_back(row_exp);
      end
   endfunction

   // one request transaction; valid is left high for a following item
   task automatic send_item(input op_type op, input logic [FONT_AW-1:0] faddr,
                            input logic [BYTE_W-1:0] fbyte,
                            input logic [CODE_W-1:0] code,
                            input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                            input logic [COLOR_W-1:0] color);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, color, y, x, code, fbyte, faddr};
      do @(posedge clock); while (!req_tready);
      if (op == OP_LOAD) begin
         font_shadow[faddr] = fbyte;
         font_loaded[faddr] = 1'b1;
      end else begin
         predict_glyph_rows(code, x, y, color);
      end
   endtask

   task automatic load_font_byte(input logic [FONT_AW-1:0] faddr,
                                 input logic [BYTE_W-1:0] fbyte);
      send_item(OP_LOAD, faddr, fbyte, CODE_W'($urandom_range(0, 255)),
                POS_W'($urandom_range(0, 4095)), POS_W'($urandom_range(0, 4095)),
                $urandom());
   endtask

   task automatic draw_char(input logic [CODE_W-1:0] code, input logic [POS_W-1:0] x,
                            input logic [POS_W-1:0] y, input logic [COLOR_W-1:0] color);
      send_item(OP_DRAW, FONT_AW'($urandom_range(0, 16383)),
                BYTE_W'($urandom_range(0, 255)), code, x, y, color);
   endtask

   // load random bytes wherever a draw of this code would read unwritten store
   task automatic prepare_glyph(input logic [CODE_W-1:0] code);
      logic [FONT_AW-1:0] a;
      for (int row = 0; row < eff_height(); row++) begin
         for (int col = 0; col < eff_width(); col += 8) begin
            a = font_byte_addr(code, row, col);
            if (!font_loaded[a]) load_font_byte(a, BYTE_W'($urandom_range(0, 255)));
         end
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [ADDR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_FRAME_BASE:   cfg_frame_base = value;
         CSR_PITCH_BYTES:  cfg_pitch      = value[PITCH_W-1:0];
         CSR_GLYPH_WIDTH:  cfg_width      = value[GW_W-1:0];
         CSR_GLYPH_HEIGHT: cfg_height     = value[GH_W-1:0];
         CSR_GLYPH_BYTES:  cfg_gbytes     = value[GB_W-1:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [ADDR_W-1:0] base, input logic [PITCH_W-1:0] pitch,
                            input logic [GW_W-1:0] w, input logic [GH_W-1:0] h,
                            input logic [GB_W-1:0] gb);
      write_reg(CSR_FRAME_BASE, base);
      write_reg(CSR_PITCH_BYTES, ADDR_W'(pitch));
      write_reg(CSR_GLYPH_WIDTH, ADDR_W'(w));
      write_reg(CSR_GLYPH_HEIGHT, ADDR_W'(h));
      write_reg(CSR_GLYPH_BYTES, ADDR_W'(gb));
      csr_valid <= 1'b0;
   endtask

   // wait for every predicted row, then let queued loads retire
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_rows.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // register reset values with an 8x16 glyph of mixed patterns
   task automatic test_reset_defaults();
      logic [BYTE_W-1:0] pat [16] = '{8'hFF, 8'h00, 8'h80, 8'h01, 8'hAA, 8'h55, 8'hF0,
                                      8'h0F, 8'hC3, 8'h3C, 8'h81, 8'h7E, 8'h18, 8'hE7,
                                      8'h42, 8'hBD};
      for (int i = 0; i < 16; i++) load_font_byte(FONT_AW'(i), pat[i]);
      draw_char(8'd0, 12'd0, 12'd0, 32'h0000_0000);
      draw_char(8'd0, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF);
   endtask

   // register extremes, saturation, empty glyphs and address wrap
   task automatic test_config_extremes();
      // top of the address space, widest pitch, last glyph at the store end
      wait_idle();
      write_reg(CSR_SPARE_IDX, {ADDR_W{1'b1}});
      configure({ADDR_W{1'b1}}, 16'hFFFF, 5'd16, 6'd1, 7'd64);
      load_font_byte(14'd16320, 8'hFF);
      load_font_byte(14'd16321, 8'h01);
      draw_char(8'd255, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF);
      draw_char(8'd255, 12'd0, 12'd0, 32'h0000_0000);
      // width above the maximum, zero pitch, glyph start wrapping the store
      wait_idle();
      configure('0, 16'd0, 5'd31, 6'd2, 7'd127);
      prepare_glyph(8'd255);
      draw_char(8'd255, 12'd1, 12'd1, $urandom());
      // zero width and height above the maximum: 32 empty rows
      wait_idle();
      configure(ADDR_W'({$urandom(), $urandom()}), 16'd4096, 5'd0, 6'd63, 7'd0);
      draw_char(8'd7, 12'd100, 12'd200, $urandom());
      // zero height gives no rows at all
      wait_idle();
      configure(ADDR_W'({$urandom(), $urandom()}), 16'd320, 5'd9, 6'd0, 7'd3);
      draw_char(8'd3, 12'd5, 12'd6, $urandom());
      load_font_byte(14'h3FFF, 8'h5A);
      // one column wide, every glyph sharing store address zero
      wait_idle();
      configure(ADDR_W'({$urandom(), $urandom()}), 16'd1, 5'd1, 6'd3, 7'd0);
      prepare_glyph(8'd200);
      draw_char(8'd200, 12'd2, 12'd3, $urandom());
   endtask

   // one random step: mostly prepared draws, some noise loads
   task automatic random_step(input logic [CODE_W-1:0] pool [4]);
      logic [CODE_W-1:0] code;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         load_font_byte(FONT_AW'($urandom_range(0, 16383)), BYTE_W'($urandom_range(0, 255)));
      end else begin
         code = (pick < 25) ? CODE_W'($urandom_range(0, 255)) : pool[$urandom_range(0, 3)];
         prepare_glyph(code);
         draw_char(code, POS_W'($urandom_range(0, 4095)), POS_W'($urandom_range(0, 4095)),
                   $urandom());
      end
   endtask

   // random configurations under the three idling patterns
   task automatic test_random_traffic();
      int send_pct [3] = '{31, 86, 0};
      int recv_pct [3] = '{86, 31, 0};
      logic [CODE_W-1:0] pool [4];
      logic [GW_W-1:0] w;
      logic [GH_W-1:0] h;
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = send_pct[ph];
         recv_idle_pct <= recv_pct[ph];
         for (int blk = 0; blk < 3; blk++) begin
            wait_idle();
            w = ($urandom_range(0, 9) < 8) ? GW_W'($urandom_range(1, 16))
                                           : GW_W'($urandom_range(0, 31));
            h = ($urandom_range(0, 9) < 9) ? GH_W'($urandom_range(1, 4))
                                           : GH_W'($urandom_range(0, 63));
            configure(ADDR_W'({$urandom(), $urandom()}), PITCH_W'($urandom_range(0, 65535)),
                      w, h, GB_W'($urandom_range(0, 127)));
            foreach (pool[i]) pool[i] = CODE_W'($urandom_range(0, 255));
            for (int step = 0; step < 4; step++) random_step(pool);
         end
      end
   endtask

   // long response hold while draws keep coming, so the request side stalls
   task automatic test_backpressure_stall();
      logic [CODE_W-1:0] code;
      wait_idle();
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      configure(ADDR_W'({$urandom(), $urandom()}), 16'd4096, 5'd16, 6'd16, 7'd32);
      code = CODE_W'($urandom_range(0, 255));
      prepare_glyph(code);
      hold_token <= hold_token + 1;
      for (int i = 0; i < 12; i++) begin
         draw_char(code, POS_W'($urandom_range(0, 4095)), POS_W'($urandom_range(0, 4095)),
                   $urandom());
      end
   endtask

   initial begin : run_tests
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 31;
      recv_idle_pct <= 86;
      test_reset_defaults();
      test_config_extremes();
      test_random_traffic();
      test_backpressure_stall();
      wait_idle();
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
